[design/slew_limited_median_filter_assert.svh]
// ----------------------------------------------------------------------------
// Slew limited median filter: assertion macros
// Shorthand for the clocked, reset-gated properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef SLEW_LIMITED_MEDIAN_FILTER_ASSERT_SVH
`define SLEW_LIMITED_MEDIAN_FILTER_ASSERT_SVH

// same-cycle implication
`define SLMF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("slmf check failed");

// next-cycle implication
`define SLMF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("slmf check failed");

`endif

[design/slmf_pkg.sv]
// ----------------------------------------------------------------------------
// Slew limited median filter: package
// Shared widths, window geometry and sample type.
// ----------------------------------------------------------------------------
package slmf_pkg;

	localparam int SampleW   = 16;
	localparam int SlewW     = 15;
	localparam int DiffW     = SampleW + 1;
	localparam int WindowLen = 5;
	localparam int SlotW     = $clog2(WindowLen);
	localparam int RankW     = $clog2(WindowLen);
	localparam int MidIdx    = WindowLen / 2;

	// 4.0 degrees at 1/128 degree per LSB
	localparam logic [SlewW-1:0] SlewReset = SlewW'(512);
	localparam logic [SlotW-1:0] SlotLast  = SlotW'(WindowLen - 1);

	typedef logic signed [SampleW-1:0] sample_t;

endpackage

[design/slmf_slew.sv]
// ----------------------------------------------------------------------------
// Slew limiter
// Clamps a sample to within slew_limit of the last output; equal passes.
// ----------------------------------------------------------------------------
module slmf_slew (
	input  slmf_pkg::sample_t                 sample,
	input  slmf_pkg::sample_t                 last,
	input  logic [slmf_pkg::SlewW-1:0]        slew_limit,
	output slmf_pkg::sample_t                 limited
);

	logic signed [slmf_pkg::DiffW-1:0] diff;
	logic signed [slmf_pkg::DiffW-1:0] lim;
	logic signed [slmf_pkg::DiffW-1:0] hi;
	logic signed [slmf_pkg::DiffW-1:0] lo;

	assign lim  = {2'b00, slew_limit};
	assign diff = {sample[slmf_pkg::SampleW-1], sample} - {last[slmf_pkg::SampleW-1], last};
	assign hi   = {last[slmf_pkg::SampleW-1], last} + lim;
	assign lo   = {last[slmf_pkg::SampleW-1], last} - lim;

	always_comb begin
		if (diff > lim) begin
			limited = hi[slmf_pkg::SampleW-1:0];
		end else if (diff < -lim) begin
			limited = lo[slmf_pkg::SampleW-1:0];
		end else begin
			limited = sample;
		end
	end

endmodule

[design/slmf_median.sv]
// ----------------------------------------------------------------------------
// Window median
// Rank network: each slot counts the slots below it (ties by index) and
// the slot of middle rank is selected.
// ----------------------------------------------------------------------------
module slmf_median (
	input  slmf_pkg::sample_t win [slmf_pkg::WindowLen],
	output slmf_pkg::sample_t median
);

	logic [slmf_pkg::RankW-1:0] rank [slmf_pkg::WindowLen];

	always_comb begin
		for (int i = 0; i < slmf_pkg::WindowLen; i++) begin
			rank[i] = '0;
			for (int j = 0; j < slmf_pkg::WindowLen; j++) begin
				if (j != i) begin
					if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
						rank[i] = rank[i] + slmf_pkg::RankW'(1);
					end
				end
			end
		end
	end

	always_comb begin
		median = '0;
		for (int i = 0; i < slmf_pkg::WindowLen; i++) begin
			if (rank[i] == slmf_pkg::RankW'(slmf_pkg::MidIdx)) begin
				median = median | win[i];
			end
		end
	end

endmodule

[design/slew_limited_median_filter.sv]
// ----------------------------------------------------------------------------
// Slew limited median filter: top level
// Median-of-five angle filter with a programmable slew limit.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per sample: s_tdata = sample, s_tuser = first_run.
//   m_* returns one item per input item: m_tdata = filtered.
//   cfg_we/cfg_wdata writes slew_limit; write only while the filter is idle.
//   An accepted item waits in the input register while the slew clamp,
//   window update and median network run on it; the result lands in the
//   output register when the item advances. Throughput is one item per
//   cycle while m_tready is high; window and last output are updated in
//   the same cycle the result is registered, so the next item sees them.
//   first_run loads every window slot with the sample and passes it out.
//   Reset clears the window, slot pointer and last output to zero and sets
//   slew_limit to 512 (4.0 degrees).
//   When m_tready is low the result holds in the output register, one more
//   item waits in the input register, and s_tready then drops.
// ----------------------------------------------------------------------------
module slew_limited_median_filter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // [15:0] sample
	input  logic [0:0]                   s_tuser,   // [0] first_run
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,   // [15:0] filtered
	input  logic                         cfg_we,
	input  logic [slmf_pkg::SlewW-1:0]   cfg_wdata
);

	logic                              valid_s1;
	slmf_pkg::sample_t                 sample_s1;
	logic                              first_s1;

	slmf_pkg::sample_t                 window_q [slmf_pkg::WindowLen];
	logic [slmf_pkg::SlotW-1:0]        slot_q;
	slmf_pkg::sample_t                 last_q;
	logic [slmf_pkg::SlewW-1:0]        slew_q;

	logic                              out_valid_q;
	slmf_pkg::sample_t                 out_data_q;

	logic                              advance;
	slmf_pkg::sample_t                 limited;
	slmf_pkg::sample_t                 win_next [slmf_pkg::WindowLen];
	slmf_pkg::sample_t                 median;
	slmf_pkg::sample_t                 result;
	logic [slmf_pkg::SlotW-1:0]        slot_next;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	slmf_slew u_slew (
		.sample     (sample_s1),
		.last       (last_q),
		.slew_limit (slew_q),
		.limited    (limited)
	);

	always_comb begin
		for (int i = 0; i < slmf_pkg::WindowLen; i++) begin
			if (first_s1) begin
				win_next[i] = sample_s1;
			end else if (slot_q == slmf_pkg::SlotW'(i)) begin
				win_next[i] = limited;
			end else begin
				win_next[i] = window_q[i];
			end
		end
	end

	slmf_median u_median (
		.win    (win_next),
		.median (median)
	);

	assign result = first_s1 ? sample_s1 : median;

	always_comb begin
		if (first_s1) begin
			slot_next = slot_q;
		end else if (slot_q == slmf_pkg::SlotLast) begin
			slot_next = '0;
		end else begin
			slot_next = slot_q + slmf_pkg::SlotW'(1);
		end
	end

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			slot_q      <= '0;
			last_q      <= '0;
			slew_q      <= slmf_pkg::SlewReset;
			for (int i = 0; i < slmf_pkg::WindowLen; i++) begin
				window_q[i] <= '0;
			end
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				slot_q      <= slot_next;
				last_q      <= result;
				for (int i = 0; i < slmf_pkg::WindowLen; i++) begin
					window_q[i] <= win_next[i];
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				slew_q <= cfg_wdata;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sample_s1 <= s_tdata;
			first_s1  <= s_tuser[0];
		end
		if (advance) begin
			out_data_q <= result;
		end
	end

endmodule

[design/slmf_checker.sv]
// ----------------------------------------------------------------------------
// Slew limited median filter: port checker
// Watches the top level ports for handshake and occupancy slips.
// ----------------------------------------------------------------------------
`include "slew_limited_median_filter_assert.svh"

module slmf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [15:0]                 m_tdata
);

	`SLMF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	`SLMF_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready)
	`SLMF_ASSERT_NOW(a_stall_only_on_block, !s_tready, m_tvalid && !m_tready)
	`SLMF_ASSERT_NOW(a_out_from_in, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind slew_limited_median_filter slmf_checker u_slmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
